// ----- rtl/core/mspr_pkg.sv -----
// Shared types and constants for the motor setpoint ramp with run/stop decision.
`timescale 1ns / 1ps

package mspr_pkg;

    localparam int unsigned VAL_W  = 16;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register reset values
    localparam logic             CLOSED_LOOP_RST  = 1'b1;
    localparam logic [VAL_W-1:0] START_ABOVE_RST  = 16'd80;
    localparam logic [VAL_W-1:0] STOP_BELOW_RST   = 16'd80;
    localparam logic [VAL_W-1:0] AIM_FLOOR_RST    = 16'd300;
    localparam logic [VAL_W-1:0] STEP_INITIAL_RST = 16'd80;
    localparam logic [VAL_W-1:0] STEP_LIMIT_RST   = 16'd100;
    localparam logic [VAL_W-1:0] AIM_INITIAL_RST  = 16'd0;

    // Register index, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_CLOSED_LOOP  = 3'd0,
        REG_START_ABOVE  = 3'd1,
        REG_STOP_BELOW   = 3'd2,
        REG_AIM_FLOOR    = 3'd3,
        REG_STEP_INITIAL = 3'd4,
        REG_STEP_LIMIT   = 3'd5,
        REG_AIM_INITIAL  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [VAL_W-1:0] setpoint;
        logic             fault;
        logic             speed_enable;
        logic             ramp_due;
    } in_word_t;

    typedef struct packed {
        logic             running;
        logic [VAL_W-1:0] aim_value;
        logic [VAL_W-1:0] step_now;
    } out_word_t;

    // Settings the datapath needs
    typedef struct packed {
        logic             closed_loop;
        logic [VAL_W-1:0] start_above;
        logic [VAL_W-1:0] stop_below;
        logic [VAL_W-1:0] aim_floor;
        logic [VAL_W-1:0] step_limit;
    } ramp_cfg_t;

endpackage

// ----- rtl/core/mspr_cfg.sv -----
// APB register bank for the ramp settings.
`timescale 1ns / 1ps

module mspr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mspr_pkg::ADDR_W-1:0]  paddr,
    input  logic [mspr_pkg::DATA_W-1:0]  pwdata,
    output logic [mspr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output mspr_pkg::ramp_cfg_t          cfg
);
    import mspr_pkg::*;

    logic             closed_loop_reg;
    logic [VAL_W-1:0] start_above_reg;
    logic [VAL_W-1:0] stop_below_reg;
    logic [VAL_W-1:0] aim_floor_reg;
    logic [VAL_W-1:0] step_initial_reg;
    logic [VAL_W-1:0] step_limit_reg;
    logic [VAL_W-1:0] aim_initial_reg;
    reg_idx_t         idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_loop_reg  <= CLOSED_LOOP_RST;
            start_above_reg  <= START_ABOVE_RST;
            stop_below_reg   <= STOP_BELOW_RST;
            aim_floor_reg    <= AIM_FLOOR_RST;
            step_initial_reg <= STEP_INITIAL_RST;
            step_limit_reg   <= STEP_LIMIT_RST;
            aim_initial_reg  <= AIM_INITIAL_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CLOSED_LOOP:  closed_loop_reg  <= pwdata[0];
                REG_START_ABOVE:  start_above_reg  <= pwdata[VAL_W-1:0];
                REG_STOP_BELOW:   stop_below_reg   <= pwdata[VAL_W-1:0];
                REG_AIM_FLOOR:    aim_floor_reg    <= pwdata[VAL_W-1:0];
                REG_STEP_INITIAL: step_initial_reg <= pwdata[VAL_W-1:0];
                REG_STEP_LIMIT:   step_limit_reg   <= pwdata[VAL_W-1:0];
                REG_AIM_INITIAL:  aim_initial_reg  <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_CLOSED_LOOP:  prdata = {{(DATA_W-1){1'b0}}, closed_loop_reg};
            REG_START_ABOVE:  prdata = {{(DATA_W-VAL_W){1'b0}}, start_above_reg};
            REG_STOP_BELOW:   prdata = {{(DATA_W-VAL_W){1'b0}}, stop_below_reg};
            REG_AIM_FLOOR:    prdata = {{(DATA_W-VAL_W){1'b0}}, aim_floor_reg};
            REG_STEP_INITIAL: prdata = {{(DATA_W-VAL_W){1'b0}}, step_initial_reg};
            REG_STEP_LIMIT:   prdata = {{(DATA_W-VAL_W){1'b0}}, step_limit_reg};
            REG_AIM_INITIAL:  prdata = {{(DATA_W-VAL_W){1'b0}}, aim_initial_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.closed_loop = closed_loop_reg;
    assign cfg.start_above = start_above_reg;
    assign cfg.stop_below  = stop_below_reg;
    assign cfg.aim_floor   = aim_floor_reg;
    assign cfg.step_limit  = step_limit_reg;

endmodule

// ----- rtl/core/mspr_core.sv -----
// Run/stop decision and ramp state, updated once per word.
`timescale 1ns / 1ps

module mspr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  mspr_pkg::in_word_t   word,
    input  mspr_pkg::ramp_cfg_t  cfg,
    output mspr_pkg::out_word_t  cur,
    output mspr_pkg::out_word_t  nxt
);
    import mspr_pkg::*;

    logic             run_reg,  run_next;
    logic [VAL_W-1:0] aim_reg,  aim_next;
    logic [VAL_W-1:0] step_reg, step_next;
    logic [VAL_W-1:0] moved;
    logic [VAL_W-1:0] clamped;
    logic [VAL_W-1:0] stepped;
    logic [VAL_W-1:0] sp;

    assign sp = word.setpoint;

    always_comb
    begin
        if (run_reg)
            run_next = !((sp < cfg.stop_below) || word.fault);
        else
            run_next = (sp > cfg.start_above) && !word.fault;
    end

    // Move toward setpoint by at most one step, then raise to the floor; the subtractions cannot wrap
    // in the arm that selects them.
    always_comb
    begin
        moved = aim_reg;
        if (sp < aim_reg)
            moved = ((aim_reg - sp) > step_reg) ? (aim_reg - step_reg) : sp;
        else
            moved = ((sp - aim_reg) > step_reg) ? (aim_reg + step_reg) : sp;
        clamped = (moved < cfg.aim_floor) ? cfg.aim_floor : moved;
        stepped = (step_reg < cfg.step_limit) ? (step_reg + VAL_W'(1)) : step_reg;
    end

    always_comb
    begin
        aim_next  = aim_reg;
        step_next = step_reg;
        if (word.ramp_due)
        begin
            if (cfg.closed_loop && !word.speed_enable)
                aim_next = '0;
            else
            begin
                // equal setpoint leaves the aim alone, even below the floor
                aim_next  = (sp == aim_reg) ? aim_reg : clamped;
                step_next = stepped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            aim_reg  <= AIM_INITIAL_RST;
            step_reg <= STEP_INITIAL_RST;
        end
        else if (advance)
        begin
            run_reg  <= run_next;
            aim_reg  <= aim_next;
            step_reg <= step_next;
        end
    end

    assign cur.running   = run_reg;
    assign cur.aim_value = aim_reg;
    assign cur.step_now  = step_reg;
    assign nxt.running   = run_next;
    assign nxt.aim_value = aim_next;
    assign nxt.step_now  = step_next;

endmodule

// ----- rtl/core/motor_setpoint_ramp_run_stop.sv -----
// Top level: word input register, ramp core, result register, APB settings.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------
//  item     | item_valid / item_ready       | mspr_pkg::in_word_t
//  result   | result_valid / result_ready   | mspr_pkg::out_word_t
//  settings | psel/penable/pwrite, pready=1 | paddr[4:2] index, pwdata
//
// One word per cycle sustained while result_ready stays high; a word passes the input register,
// then the result register, the ramp state updating as a word moves between them.
// Reset clears the run flag and loads aim and step with their reset values.
// A stalled result holds the input register; item_ready drops only when both
// registers are full and result_ready is low.
`timescale 1ns / 1ps

module motor_setpoint_ramp_run_stop (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  mspr_pkg::in_word_t           item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output mspr_pkg::out_word_t          result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mspr_pkg::ADDR_W-1:0]  paddr,
    input  logic [mspr_pkg::DATA_W-1:0]  pwdata,
    output logic [mspr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import mspr_pkg::*;

    in_word_t  s1_reg;
    logic      s1_valid_reg, s1_valid_next;
    out_word_t result_reg;
    logic      result_valid_reg, result_valid_next;
    logic      out_free;
    logic      advance;
    logic      take;
    ramp_cfg_t cfg;
    out_word_t cur;
    out_word_t nxt;

    mspr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mspr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (s1_reg),
        .cfg     (cfg),
        .cur     (cur),
        .nxt     (nxt)
    );

    assign out_free   = !result_valid_reg || result_ready;
    assign advance    = s1_valid_reg && out_free;
    assign item_ready = !s1_valid_reg || out_free;
    assign take       = item_valid && item_ready;

    assign s1_valid_next     = take || (s1_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_reg <= item;
        if (advance)
            result_reg <= nxt;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && result_valid_reg && !result_ready) |-> !item_ready)
        else $error("item_ready high with both stages full and output stalled");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("word moved on but no result shown");

    a_no_due_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_reg.ramp_due) |=>
        (result_reg.aim_value == $past(cur.aim_value)) &&
        (result_reg.step_now == $past(cur.step_now)))
        else $error("aim or step changed without ramp due");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reg.fault) |=> !result_reg.running)
        else $error("running reported during fault");

endmodule

// ----- sim/motor_setpoint_ramp_run_stop_tb.sv -----
// Testbench for the motor setpoint ramp: random and directed words checked against a ramp model.
`timescale 1ns / 1ps

module motor_setpoint_ramp_run_stop_tb;

    import mspr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_WORDS  = 150;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned MAX_REPORTS  = 40;
    // spare register slot, decoded by nothing
    localparam logic [2:0]  REG_SPARE    = 3'd7;

    // Expected run flag, aim and step for every accepted word, in order.
    class ramp_scoreboard;
        bit         closed_loop;
        logic [15:0] start_above;
        logic [15:0] stop_below;
        logic [15:0] aim_floor;
        logic [15:0] step_init;
        logic [15:0] step_limit;
        logic [15:0] aim_init;
        bit         run_on;
        logic [15:0] aim;
        logic [15:0] step;
        out_word_t  pending_q[$];
        int         errors;

        function new();
            closed_loop = CLOSED_LOOP_RST;
            start_above = START_ABOVE_RST;
            stop_below  = STOP_BELOW_RST;
            aim_floor   = AIM_FLOOR_RST;
            step_init   = STEP_INITIAL_RST;
            step_limit  = STEP_LIMIT_RST;
            aim_init    = AIM_INITIAL_RST;
            run_on      = 1'b0;
            aim         = AIM_INITIAL_RST;
            step        = STEP_INITIAL_RST;
            errors      = 0;
        endfunction

        task report(input string msg);
            if (errors < MAX_REPORTS)
                $display("%0t: %s", $time, msg);
            errors++;
        endtask

        // the core never reads the aim/step initial registers, so writing them changes nothing
        task set_reg(input logic [2:0] idx, input logic [15:0] v);
            case (idx)
                REG_CLOSED_LOOP:  closed_loop = v[0];
                REG_START_ABOVE:  start_above = v;
                REG_STOP_BELOW:   stop_below  = v;
                REG_AIM_FLOOR:    aim_floor   = v;
                REG_STEP_INITIAL: step_init   = v;
                REG_STEP_LIMIT:   step_limit  = v;
                REG_AIM_INITIAL:  aim_init    = v;
                default: ;
            endcase
        endtask

        task note_input(input in_word_t w);
            int unsigned sp;
            int unsigned cur;
            int unsigned st;
            int unsigned nx;
            out_word_t   exp_w;
            sp  = 32'(w.setpoint);
            cur = 32'(aim);
            st  = 32'(step);
            if (!run_on)
            begin
                if (sp > start_above && !w.fault)
                    run_on = 1'b1;
            end
            else if (sp < stop_below || w.fault)
            begin
                run_on = 1'b0;
            end
            if (w.ramp_due)
            begin
                if (closed_loop && !w.speed_enable)
                begin
                    aim = '0;
                end
                else
                begin
                    nx = cur;
                    if (sp < cur)
                    begin
                        nx = (cur - sp > st) ? cur - st : sp;
                        if (nx < aim_floor)
                            nx = aim_floor;
                    end
                    else if (sp > cur)
                    begin
                        nx = (sp - cur > st) ? cur + st : sp;
                        if (nx < aim_floor)
                            nx = aim_floor;
                    end
                    aim = nx[15:0];
                    if (step < step_limit)
                        step = step + 16'd1;
                end
            end
            exp_w.running   = run_on;
            exp_w.aim_value = aim;
            exp_w.step_now  = step;
            pending_q.push_back(exp_w);
        endtask

        task check_result(input out_word_t r);
            out_word_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("result word %h with nothing pending", r));
            end
            else
            begin
                e = pending_q.pop_front();
                if (r.running !== e.running)
                    report($sformatf("running %b, want %b", r.running, e.running));
                if (r.aim_value !== e.aim_value)
                    report($sformatf("aim_value %0d, want %0d", r.aim_value, e.aim_value));
                if (r.step_now !== e.step_now)
                    report($sformatf("step_now %0d, want %0d", r.step_now, e.step_now));
            end
        endtask

        task close_out();
            if (pending_q.size() != 0)
                report($sformatf("%0d result words never arrived", pending_q.size()));
        endtask
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    in_word_t            item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    out_word_t           result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ramp_scoreboard      sb = new();
    int unsigned         cycles     = 0;
    int                  burst_left = 0;
    bit                  hold_req   = 1'b0;
    bit                  hold_done  = 1'b0;

    motor_setpoint_ramp_run_stop dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("motor_setpoint_ramp_run_stop_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_input(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // Receiver: stretches of free flow, random stalls and heavy stalls, plus one long hold.
    initial
    begin
        int mode;
        int len;
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(8, 64);
            repeat (len)
            begin
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] near(input int centre, input int span);
        int v;
        v = centre - span + int'($urandom_range(0, 2 * span));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    function automatic in_word_t mk(input logic [15:0] sp, input bit f, input bit en,
                                    input bit due);
        in_word_t w;
        w.setpoint     = sp;
        w.fault        = f;
        w.speed_enable = en;
        w.ramp_due     = due;
        return w;
    endfunction

    // Setpoints cluster round the thresholds, the aim and the floor.
    function automatic in_word_t pick_word();
        in_word_t w;
        case ($urandom_range(0, 9))
            0:       w.setpoint = near(int'(sb.start_above), 3);
            1:       w.setpoint = near(int'(sb.stop_below), 3);
            2, 3:    w.setpoint = near(int'(sb.aim), int'(sb.step) + 2);
            4:       w.setpoint = near(int'(sb.aim_floor), 4);
            5:       w.setpoint = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            6:       w.setpoint = sb.aim;
            default: w.setpoint = 16'($urandom_range(0, 65535));
        endcase
        w.fault        = ($urandom_range(0, 9) == 0);
        w.speed_enable = ($urandom_range(0, 3) != 0);
        w.ramp_due     = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Offer one word; bursts of random length, then an occasional gap.
    task automatic offer(input in_word_t w);
        int gap;
        item_valid <= 1'b1;
        item       <= w;
        do @(posedge clk); while (!item_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Let every pending word come out before touching the registers.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic apply_settings(input bit cl, input logic [15:0] start, input logic [15:0] stop,
                                  input logic [15:0] floor_v, input logic [15:0] step_i,
                                  input logic [15:0] limit, input logic [15:0] aim_i);
        write_reg(REG_CLOSED_LOOP, {15'd0, cl});
        write_reg(REG_START_ABOVE, start);
        write_reg(REG_STOP_BELOW, stop);
        write_reg(REG_AIM_FLOOR, floor_v);
        write_reg(REG_STEP_INITIAL, step_i);
        write_reg(REG_STEP_LIMIT, limit);
        write_reg(REG_AIM_INITIAL, aim_i);
    endtask

    initial
    begin
        in_word_t    dir_q[$];
        logic [15:0] start;
        int unsigned p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold edges, fault, speed disabled, equal aim, floor clamp
        dir_q.push_back(mk(16'd0, 0, 1, 1));
        dir_q.push_back(mk(16'd80, 0, 1, 0));
        dir_q.push_back(mk(16'd81, 1, 1, 0));
        dir_q.push_back(mk(16'd81, 0, 1, 1));
        dir_q.push_back(mk(16'hffff, 0, 1, 1));
        dir_q.push_back(mk(16'd80, 0, 1, 1));
        dir_q.push_back(mk(16'd300, 0, 1, 1));
        dir_q.push_back(mk(16'd79, 0, 0, 1));
        dir_q.push_back(mk(16'd0, 0, 1, 1));
        dir_q.push_back(mk(16'hffff, 1, 1, 0));
        dir_q.push_back(mk(16'd200, 0, 1, 0));
        dir_q.push_back(mk(16'd200, 1, 0, 0));
        repeat (8) dir_q.push_back(mk(16'hffff, 0, 1, 1));
        foreach (dir_q[i])
            offer(dir_q[i]);
        settle();

        // open loop: speed_enable no longer forces the aim to zero
        apply_settings(1'b0, START_ABOVE_RST, STOP_BELOW_RST, AIM_FLOOR_RST,
                       STEP_INITIAL_RST, STEP_LIMIT_RST, AIM_INITIAL_RST);
        offer(mk(16'd5000, 0, 0, 1));
        offer(mk(16'd5000, 0, 0, 1));
        offer(mk(16'd0, 0, 0, 1));
        settle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: apply_settings(1'b0, 16'd0, 16'hffff, 16'd0, 16'd0, 16'hffff, 16'hffff);
                1: apply_settings(1'b1, 16'hffff, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0);
                2:
                begin
                    apply_settings(CLOSED_LOOP_RST, START_ABOVE_RST, STOP_BELOW_RST,
                                   AIM_FLOOR_RST, STEP_INITIAL_RST, STEP_LIMIT_RST,
                                   AIM_INITIAL_RST);
                    write_reg(REG_SPARE, 16'hffff);
                end
                default:
                begin
                    start = 16'($urandom_range(0, 3000));
                    apply_settings(1'($urandom_range(0, 1)), start, near(int'(start), 150),
                                   16'($urandom_range(0, 1500)),
                                   16'($urandom_range(0, 65535)),
                                   $urandom_range(0, 1) ? near(int'(sb.step), 40)
                                                        : 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)));
                end
            endcase
            // receiver sits on its output for a while; the input side backs up
            if (p == 3)
                hold_req = 1'b1;
            repeat (PHASE_WORDS)
                offer(pick_word());
            settle();
        end

        repeat (8) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("motor_setpoint_ramp_run_stop_tb: clean");
        else
            $display("motor_setpoint_ramp_run_stop_tb: errors");
        $finish;
    end

endmodule
